>>> rtl/hlbs_pkg.sv
// ----------------------------------------------------------------------------
// hlbs_pkg
// Types and constants shared by the hot-plug link bring-up sequencer.
// ----------------------------------------------------------------------------
package hlbs_pkg;

  localparam int unsigned DelayW    = 11;
  localparam int unsigned AttemptW  = 3;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 8;

  localparam logic [DelayW-1:0]   StabilizeDelayRst = DelayW'(40);
  localparam logic [DelayW-1:0]   PlugCheckDelayRst = DelayW'(10);
  localparam logic [DelayW-1:0]   EdidRetryDelayRst = DelayW'(60);
  localparam logic [AttemptW-1:0] MaxEdidAttemptsRst = AttemptW'(5);
  localparam logic [AttemptW-1:0] FailSat            = '1;

  typedef enum logic [PhaseW-1:0] {
    PH_RESET      = 3'd0,
    PH_CHECK_PLUG = 3'd1,
    PH_CHECK_EDID = 3'd2,
    PH_DISABLED   = 3'd3,
    PH_ENABLED    = 3'd4,
    PH_BOOT       = 3'd5
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_TICK     = 2'd0,
    KIND_HPD_IRQ  = 2'd1,
    KIND_SHUTDOWN = 2'd2
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STABILIZE_DELAY  = 2'd0,
    CFG_PLUG_CHECK_DELAY = 2'd1,
    CFG_EDID_RETRY_DELAY = 2'd2,
    CFG_MAX_EDID_ATTEMPTS = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [DelayW-1:0]   stabilize_delay_ms;
    logic [DelayW-1:0]   plug_check_delay_ms;
    logic [DelayW-1:0]   edid_retry_delay_ms;
    logic [AttemptW-1:0] max_edid_attempts;
  } cfg_t;

  typedef struct packed {
    phase_e              phase;
    logic                event_pending;
    logic                halted;
    logic [DelayW-1:0]   countdown;
    logic                countdown_armed;
    logic [AttemptW-1:0] edid_failures;
    logic                display_on;
  } seq_state_t;

  typedef struct packed {
    logic wait_armed;
    logic publish_modes_pulse;
    logic enable_pulse;
    logic disable_pulse;
    phase_e ctrl_state;
  } result_t;

endpackage

>>> rtl/hlbs_step.sv
// ----------------------------------------------------------------------------
// hlbs_step
// Next-state and action logic for one tick, interrupt or shutdown request.
// ----------------------------------------------------------------------------
module hlbs_step
  import hlbs_pkg::*;
(
  input  seq_state_t       state_i,
  input  cfg_t             cfg_i,
  input  logic [KindW-1:0] kind_i,
  input  logic             hpd_level_i,
  input  logic             edid_ok_i,
  input  logic             mode_ok_i,
  output seq_state_t       state_o,
  output result_t          result_o
);

  logic                run_step;
  logic                arm_req;
  logic [DelayW-1:0]   arm_delay;
  logic                turn_off;
  logic                pulse_on;
  logic                pulse_pub;
  logic [AttemptW-1:0] fails_inc;
  seq_state_t          nx;

  assign fails_inc = (state_i.edid_failures == FailSat) ? FailSat
                                                         : state_i.edid_failures + 1'b1;

  always_comb begin
    nx        = state_i;
    run_step  = 1'b0;
    arm_req   = 1'b0;
    arm_delay = '0;
    turn_off  = 1'b0;
    pulse_on  = 1'b0;
    pulse_pub = 1'b0;

    case (kind_i)
      KIND_TICK: begin
        if (state_i.countdown_armed) begin
          if (state_i.countdown == '0) begin
            nx.countdown_armed = 1'b0;
            run_step           = 1'b1;
          end else begin
            nx.countdown = state_i.countdown - 1'b1;
          end
        end
      end
      KIND_HPD_IRQ: begin
        nx.event_pending = 1'b1;
        arm_req          = 1'b1;
      end
      KIND_SHUTDOWN: begin
        nx.halted          = 1'b1;
        nx.countdown_armed = 1'b0;
      end
      default: begin
      end
    endcase

    if (run_step) begin
      nx.event_pending = 1'b0;
      if (state_i.event_pending) begin
        if (!(state_i.phase == PH_ENABLED && hpd_level_i)) begin
          nx.phase  = (state_i.phase == PH_BOOT && hpd_level_i) ? PH_CHECK_PLUG : PH_RESET;
          arm_req   = 1'b1;
          arm_delay = cfg_i.stabilize_delay_ms;
        end
      end else begin
        unique case (state_i.phase)
          PH_RESET: begin
            turn_off  = 1'b1;
            nx.phase  = PH_CHECK_PLUG;
            arm_req   = 1'b1;
            arm_delay = cfg_i.plug_check_delay_ms;
          end
          PH_CHECK_PLUG: begin
            if (hpd_level_i) begin
              nx.edid_failures = '0;
              nx.phase         = PH_CHECK_EDID;
              arm_req          = 1'b1;
              arm_delay        = cfg_i.edid_retry_delay_ms;
            end else begin
              turn_off = 1'b1;
              nx.phase = PH_DISABLED;
            end
          end
          PH_CHECK_EDID: begin
            if (!hpd_level_i) begin
              turn_off = 1'b1;
              nx.phase = PH_DISABLED;
            end else if (!edid_ok_i) begin
              nx.edid_failures = fails_inc;
              if (fails_inc >= cfg_i.max_edid_attempts) begin
                turn_off = 1'b1;
                nx.phase = PH_DISABLED;
              end else begin
                nx.phase  = PH_CHECK_EDID;
                arm_req   = 1'b1;
                arm_delay = cfg_i.edid_retry_delay_ms;
              end
            end else begin
              pulse_pub = 1'b1;
              if (!mode_ok_i) begin
                turn_off = 1'b1;
                nx.phase = PH_DISABLED;
              end else begin
                nx.phase = PH_ENABLED;
                arm_req  = 1'b1;
              end
            end
          end
          PH_ENABLED: begin
            pulse_on      = 1'b1;
            nx.display_on = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    if (arm_req) begin
      nx.countdown_armed = !state_i.halted;
      if (!state_i.halted) begin
        nx.countdown = arm_delay;
      end
    end

    if (turn_off && state_i.display_on) begin
      nx.display_on = 1'b0;
    end
  end

  assign state_o                      = nx;
  assign result_o.ctrl_state          = nx.phase;
  assign result_o.disable_pulse       = turn_off && state_i.display_on;
  assign result_o.enable_pulse        = pulse_on;
  assign result_o.publish_modes_pulse = pulse_pub;
  assign result_o.wait_armed          = nx.countdown_armed;

endmodule

>>> rtl/hotplug_link_bringup_sequencer.sv
// ----------------------------------------------------------------------------
// hotplug_link_bringup_sequencer
// Display hot-plug bring-up controller driven by millisecond ticks and events.
// ----------------------------------------------------------------------------
// Results: one result per request, registered at acceptance and shown in the next cycle.
// Throughput: one request per cycle; the output register reloads in the same
// cycle its result is taken, so a stalled output stalls the input only.
// Reset: controller in bootloader takeover with an event pending, countdown
// idle, display assumed on, delay and attempt registers at their defaults.
// ----------------------------------------------------------------------------
module hotplug_link_bringup_sequencer
  import hlbs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] hpd_level, [1] edid_ok, [2] mode_ok, [7:3] zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [KindW-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [2:0] ctrl_state, [3] disable_pulse, [4] enable_pulse,
  // [5] publish_modes_pulse, [6] wait_armed, [7] zero
  output logic [OutDataW-1:0]  m_axis_tdata
);

  cfg_t       cfg_q;
  seq_state_t state_q;
  seq_state_t state_d;
  result_t    result_d;
  result_t    result_q;
  logic       out_valid_q;
  logic       in_accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stabilize_delay_ms  <= StabilizeDelayRst;
      cfg_q.plug_check_delay_ms <= PlugCheckDelayRst;
      cfg_q.edid_retry_delay_ms <= EdidRetryDelayRst;
      cfg_q.max_edid_attempts   <= MaxEdidAttemptsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_STABILIZE_DELAY:   cfg_q.stabilize_delay_ms  <= cfg_data_i;
        CFG_PLUG_CHECK_DELAY:  cfg_q.plug_check_delay_ms <= cfg_data_i;
        CFG_EDID_RETRY_DELAY:  cfg_q.edid_retry_delay_ms <= cfg_data_i;
        CFG_MAX_EDID_ATTEMPTS: cfg_q.max_edid_attempts   <= cfg_data_i[AttemptW-1:0];
        default: begin
        end
      endcase
    end
  end

  hlbs_step u_step (
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .kind_i      (s_axis_tuser),
    .hpd_level_i (s_axis_tdata[0]),
    .edid_ok_i   (s_axis_tdata[1]),
    .mode_ok_i   (s_axis_tdata[2]),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= PH_BOOT;
      state_q.event_pending   <= 1'b1;
      state_q.halted          <= 1'b0;
      state_q.countdown       <= '0;
      state_q.countdown_armed <= 1'b0;
      state_q.edid_failures   <= '0;
      state_q.display_on      <= 1'b1;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

`ifndef SYNTH
  a_halt_never_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halted |-> !state_q.countdown_armed)
    else $error("countdown armed while halted");

  a_armed_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.wait_armed == state_q.countdown_armed))
    else $error("reported countdown state differs from controller");

  a_disable_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.disable_pulse) |-> !state_q.display_on)
    else $error("display still on after disable");

  a_enable_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.enable_pulse) |->
      (state_q.display_on && state_q.phase == PH_ENABLED))
    else $error("enable outside enabled phase");

  a_publish_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.publish_modes_pulse) |->
      (result_q.ctrl_state == PH_ENABLED || result_q.ctrl_state == PH_DISABLED))
    else $error("modes published without leaving edid check");
`endif

endmodule
